/* src/cdq_pkg.sv */
// Package for the circular deque: sizes, codes, memory request type and index helpers.
`default_nettype none
package cdq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(CAPACITY - 1) : i - IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

/* src/cdq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/cdq_ctrl.sv */
// Deque controller: head/tail/count registers, slot memory requests and the result register.
`default_nettype none
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [1:0]        in_tuser,
  input  wire logic [DATA_W-1:0] in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic                   out_ok,
  output logic      [DATA_W-1:0] out_value,
  output logic      [OCC_W-1:0]  out_occ,
  output mem_req_t               mem_req,
  input  wire logic [DATA_W-1:0] mem_rdata
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              in_fire;
  mode_t             mode;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign mode = mode_t'(in_tuser);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ok_nxt        = ok_r;
    value_nxt     = value_r;
    occ_nxt       = occ_r;
    mem_req       = '0;
    mem_req.wdata = in_tdata;
    in_tready     = (state_r == S_IDLE) && (!out_valid_r || out_tready);
    in_fire       = in_tvalid && in_tready;
    occ_ext       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
              ok_nxt = 1'b0;
              if (cnt_r != CNT_W'(CAPACITY)) begin
                ok_nxt     = 1'b1;
                mem_req.we = 1'b1;
                cnt_nxt    = cnt_r + CNT_W'(1);
                if (cnt_r == '0) begin
                  head_nxt      = '0;
                  tail_nxt      = '0;
                  mem_req.waddr = '0;
                end else if (mode == MODE_PUSH_FRONT) begin
                  head_nxt      = idx_prev(head_r);
                  mem_req.waddr = idx_prev(head_r);
                end else begin
                  tail_nxt      = idx_next(tail_r);
                  mem_req.waddr = idx_next(tail_r);
                end
              end
              occ_ext       = {{OCC_W{1'b0}}, cnt_nxt};
              out_valid_nxt = 1'b1;
              value_nxt     = '0;
              occ_nxt       = occ_ext[OCC_W-1:0];
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
              if (cnt_r != '0) begin
                mem_req.re = 1'b1;
                cnt_nxt    = cnt_r - CNT_W'(1);
                state_nxt  = S_READ;
                if (mode == MODE_POP_FRONT) begin
                  mem_req.raddr = head_r;
                  head_nxt      = idx_next(head_r);
                end else begin
                  mem_req.raddr = tail_r;
                  tail_nxt      = idx_prev(tail_r);
                end
                if (cnt_r == CNT_W'(1)) begin
                  head_nxt = '0;
                  tail_nxt = '0;
                end
              end else begin
                out_valid_nxt = 1'b1;
                ok_nxt        = 1'b0;
                value_nxt     = '0;
                occ_nxt       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // slot data arrives in the cycle after the read; result reg is free here
        occ_ext       = {{OCC_W{1'b0}}, cnt_r};
        out_valid_nxt = 1'b1;
        ok_nxt        = 1'b1;
        value_nxt     = mem_rdata;
        occ_nxt       = occ_ext[OCC_W-1:0];
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    value_r <= value_nxt;
    occ_r   <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_ok     = ok_r;
  assign out_value  = value_r;
  assign out_occ    = occ_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("pointers not parked while empty");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("pop data would overwrite a pending result");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_REAR)
     && cnt_r == CNT_W'(CAPACITY)) |=> $stable(cnt_r) && !ok_r)
    else $error("refused push changed the queue");

  a_pop_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (mode == MODE_POP_FRONT || mode == MODE_POP_REAR)
     && cnt_r == '0) |=> (cnt_r == '0) && out_valid_r && !ok_r)
    else $error("empty pop misreported");

endmodule
`default_nettype wire

/* src/circular_deque.sv */
// Top level of the circular deque: stream ports, controller and slot memory.
//
// Fixed-capacity double-ended queue (CAPACITY entries of 32 bits) kept in one
// synchronous RAM with registered read data. Each input item is an
// operation in in_tuser (push front, push rear, pop front, pop rear) with the
// push value in in_tdata; every item yields exactly one result item carrying
// an ok flag, the popped value (zero unless a pop succeeded) and the count of
// stored elements after the operation. A push into a full queue and a pop
// from an empty one return ok = 0 and leave the queue as it was. A push or a
// failed pop registers its result in the cycle after acceptance; a successful
// pop reads the RAM, then registers the slot data. A new item is taken whenever
// the controller is not waiting on a RAM read and the result register is empty
// or being drained in that cycle, so pushes stream at one item per cycle while
// results drain; a pop blocks new items until its read is done. No clearing
// pass is needed after reset: only slots written by a push are ever read.
`default_nettype none
module circular_deque
  import cdq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] push_value
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] pop_value, [36:32] occupancy, [39:37] zero
  output logic      [0:0]  out_tuser   // [0] ok
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              ok;
  logic [DATA_W-1:0] pop_value;
  logic [OCC_W-1:0]  occupancy;

  // head, tail, count and the result register live in the controller
  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_ok     (ok),
    .out_value  (pop_value),
    .out_occ    (occupancy),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // slot storage; contents undefined until a push writes them
  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = {3'b000, occupancy, pop_value};
  assign out_tuser = ok;

endmodule
`default_nettype wire
